/* src/lwm_pkg.sv */
// Package for the LZSS window match encoder.
// Holds the state encoding, register indexes, port widths and the array control struct.
// No dependencies.
`default_nettype none

package lwm_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 11;
    localparam int LENGTH_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SRCH_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH      = 2'd2;

    localparam logic [OFFSET_W-1:0] RST_SRCH_LIMIT     = 11'd1024;
    localparam logic [LENGTH_W-1:0] RST_LOOKAHEAD_SIZE = 6'd32;
    localparam logic [LENGTH_W-1:0] RST_MIN_MATCH      = 6'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } lwm_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } lwm_arr_ctrl_t;

endpackage

`default_nettype wire

/* src/lwm_byte_store.sv */
// Ring store of history and pending bytes: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module lwm_byte_store #(
    parameter int DEPTH = 1056,
    parameter int AW    = 11
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/lwm_cell.sv */
// One match cell: holds one pattern byte and extends the run length handed on by its neighbor.
// Depends on lwm_pkg.
`default_nettype none

module lwm_cell import lwm_pkg::*; #(
    parameter int IDX = 0,
    parameter int RW  = 6
) (
    input  wire logic          aclk,
    input  wire lwm_arr_ctrl_t ctrl,
    input  wire logic          en,
    input  wire logic [7:0]    stream_byte,
    input  wire logic [7:0]    pat_in,
    output logic      [7:0]    pat_out,
    input  wire logic [RW-1:0] run_in,
    output logic      [RW-1:0] run_out
);

    logic [7:0]    pat_reg;
    logic [RW-1:0] run_reg;
    logic [RW-1:0] run_next;

    always_comb begin
        if (en && run_in == RW'(IDX) && stream_byte == pat_reg) begin
            run_next = RW'(IDX + 1);
        end else begin
            run_next = run_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            pat_reg <= pat_in;
        end
        if (ctrl.step) begin
            run_reg <= run_next;
        end
    end

    assign pat_out = pat_reg;
    assign run_out = run_reg;

endmodule

`default_nettype wire

/* src/lwm_match_array.sv */
// Row of match cells: pattern bytes shift in from the far end, run lengths travel toward it.
// Depends on lwm_pkg and lwm_cell.
`default_nettype none

module lwm_match_array import lwm_pkg::*; #(
    parameter int LOOKAHEAD = 32,
    parameter int RW        = 6
) (
    input  wire logic          aclk,
    input  wire lwm_arr_ctrl_t ctrl,
    input  wire logic [RW-1:0] lim,
    input  wire logic [7:0]    data_in,
    output logic      [RW-1:0] run_len,
    output logic      [7:0]    head_byte
);

    logic [7:0]    pat_w [LOOKAHEAD+1];
    logic [RW-1:0] run_w [LOOKAHEAD+1];

    assign pat_w[LOOKAHEAD] = data_in;
    assign run_w[0]         = '0;

    for (genvar j = 0; j < LOOKAHEAD; j++) begin : g_cell
        logic lane_en;
        assign lane_en = RW'(j) < lim;
        lwm_cell #(
            .IDX (j),
            .RW  (RW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .en          (lane_en),
            .stream_byte (data_in),
            .pat_in      (pat_w[j+1]),
            .pat_out     (pat_w[j]),
            .run_in      (run_w[j]),
            .run_out     (run_w[j+1])
        );
    end

    assign run_len   = run_w[LOOKAHEAD];
    assign head_byte = pat_w[0];

endmodule

`default_nettype wire

/* src/lzss_window_match_encoder_top.sv */
// Top level of the greedy LZSS encoder: control, configuration registers and token output.
// Depends on lwm_pkg, lwm_byte_store and lwm_match_array.
//
// Bytes enter one item per cycle while no token is due. When a token is due the block
// stops taking bytes and codes it: a setup state, a load state that reads the LOOKAHEAD
// bytes at the coding position into the cell row, a scan state that streams maxoff +
// LOOKAHEAD - 1 bytes, from maxoff back in the history, through the row from the single
// read port of the byte store, a drain state and a decision state, where maxoff = min(search
// limit, WINDOW, history). The scan state is skipped when no offset is searched, and the
// decision state waits for the output register to free up. A finished token waits in that
// register, and once no further token is due bytes are taken again while it waits.
`default_nettype none

module lzss_window_match_encoder_top import lwm_pkg::*; #(
    parameter int WINDOW    = 1024,
    parameter int LOOKAHEAD = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    input  wire logic                  s_last_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_is_literal,
    output logic      [BYTE_W-1:0]     m_literal_value,
    output logic      [OFFSET_W-1:0]   m_match_offset,
    output logic      [LENGTH_W-1:0]   m_match_length,
    output logic                       m_stream_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE = WINDOW + LOOKAHEAD;
    localparam int AW    = $clog2(STORE);
    localparam int HW    = $clog2(WINDOW + 1);
    localparam int RW    = $clog2(LOOKAHEAD + 1);

    lwm_state_t state_reg, state_next;

    logic [OFFSET_W-1:0] srch_limit_reg;
    logic [LENGTH_W-1:0] lookahead_size_reg;
    logic [LENGTH_W-1:0] min_match_reg;

    logic [AW-1:0] wptr_reg, wptr_next;
    logic [RW-1:0] pending_reg, pending_next;
    logic [HW-1:0] history_reg, history_next;
    logic          last_mode_reg, last_mode_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] scan_ptr_reg, scan_ptr_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          drain_reg, drain_next;
    logic [HW-1:0] maxoff_reg, maxoff_next;
    logic [RW-1:0] lim_reg, lim_next;

    logic          rd_valid_reg;
    logic          rd_scan_reg;
    logic [AW-1:0] chain_cnt_reg;
    logic          eval_en_reg;
    logic [HW-1:0] off_cnt_reg;
    logic [RW-1:0] best_len_reg;
    logic [HW-1:0] best_off_reg;
    logic          scan_init;

    logic                m_valid_reg;
    logic                is_literal_reg;
    logic [BYTE_W-1:0]   literal_value_reg;
    logic [OFFSET_W-1:0] match_offset_reg;
    logic [LENGTH_W-1:0] match_length_reg;
    logic                stream_end_reg;
    logic                out_load;

    logic          rd_en, rd_scan, wr_en;
    logic [7:0]    rd_data;
    logic [RW-1:0] run_len;
    logic [7:0]    head_byte;
    lwm_arr_ctrl_t arr_ctrl;

    logic [RW-1:0]       cap, depth, lim;
    logic [HW-1:0]       srch, maxoff;
    logic [LENGTH_W-1:0] mm;
    logic [AW:0]         cp_wide, scan_wide;
    logic [AW-1:0]       cp;
    logic                is_match;
    logic [RW-1:0]       used, pending_left;
    logic [HW:0]         hist_sum;
    logic                more;
    logic [RW-1:0]       pending_inc;

    always_comb begin
        if (32'(lookahead_size_reg) > 32'(LOOKAHEAD)) begin
            cap = RW'(LOOKAHEAD);
        end else begin
            cap = RW'(lookahead_size_reg);
        end
        depth = (cap == '0) ? RW'(1) : cap;
        if (32'(srch_limit_reg) > 32'(WINDOW)) begin
            srch = HW'(WINDOW);
        end else begin
            srch = HW'(srch_limit_reg);
        end
        maxoff = (srch < history_reg) ? srch : history_reg;
        lim    = (cap < pending_reg) ? cap : pending_reg;
        mm     = (min_match_reg == '0) ? LENGTH_W'(1) : min_match_reg;
        if ({1'b0, wptr_reg} >= (AW+1)'(pending_reg)) begin
            cp_wide = {1'b0, wptr_reg} - (AW+1)'(pending_reg);
        end else begin
            cp_wide = {1'b0, wptr_reg} + (AW+1)'(STORE) - (AW+1)'(pending_reg);
        end
        cp = cp_wide[AW-1:0];
        if ({1'b0, cp} >= (AW+1)'(maxoff)) begin
            scan_wide = {1'b0, cp} - (AW+1)'(maxoff);
        end else begin
            scan_wide = {1'b0, cp} + (AW+1)'(STORE) - (AW+1)'(maxoff);
        end
        is_match     = (best_len_reg != '0) && (32'(best_len_reg) >= 32'(mm));
        used         = is_match ? best_len_reg : RW'(1);
        pending_left = pending_reg - used;
        hist_sum     = (HW+1)'(history_reg) + (HW+1)'(used);
        more         = last_mode_reg ? (pending_left != '0) : (pending_left >= depth);
        pending_inc  = pending_reg + RW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        pending_next   = pending_reg;
        history_next   = history_reg;
        last_mode_next = last_mode_reg;
        rd_ptr_next    = rd_ptr_reg;
        scan_ptr_next  = scan_ptr_reg;
        cnt_next       = cnt_reg;
        drain_next     = drain_reg;
        maxoff_next    = maxoff_reg;
        lim_next       = lim_reg;
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_scan        = 1'b0;
        scan_init      = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    wr_en          = 1'b1;
                    wptr_next      = (wptr_reg == AW'(STORE - 1)) ? '0 : wptr_reg + AW'(1);
                    pending_next   = pending_inc;
                    last_mode_next = s_last_byte;
                    if (s_last_byte || pending_inc >= depth) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                maxoff_next   = maxoff;
                lim_next      = lim;
                rd_ptr_next   = cp;
                scan_ptr_next = scan_wide[AW-1:0];
                cnt_next      = AW'(LOOKAHEAD);
                scan_init     = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                rd_en       = 1'b1;
                rd_ptr_next = (rd_ptr_reg == AW'(STORE - 1)) ? '0 : rd_ptr_reg + AW'(1);
                cnt_next    = cnt_reg - AW'(1);
                if (cnt_reg == AW'(1)) begin
                    if (maxoff_reg == '0) begin
                        drain_next = 1'b1;
                        state_next = ST_DRAIN;
                    end else begin
                        rd_ptr_next = scan_ptr_reg;
                        cnt_next    = AW'(maxoff_reg) + AW'(LOOKAHEAD - 1);
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en       = 1'b1;
                rd_scan     = 1'b1;
                rd_ptr_next = (rd_ptr_reg == AW'(STORE - 1)) ? '0 : rd_ptr_reg + AW'(1);
                cnt_next    = cnt_reg - AW'(1);
                if (cnt_reg == AW'(1)) begin
                    drain_next = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b0;
                if (!drain_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    pending_next = pending_left;
                    history_next = (hist_sum > (HW+1)'(WINDOW)) ? HW'(WINDOW) : hist_sum[HW-1:0];
                    if (more) begin
                        state_next = ST_SETUP;
                    end else begin
                        state_next = ST_IDLE;
                        if (last_mode_reg) begin
                            history_next   = '0;
                            pending_next   = '0;
                            wptr_next      = '0;
                            last_mode_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srch_limit_reg     <= RST_SRCH_LIMIT;
            lookahead_size_reg <= RST_LOOKAHEAD_SIZE;
            min_match_reg      <= RST_MIN_MATCH;
            wptr_reg           <= '0;
            pending_reg        <= '0;
            history_reg        <= '0;
            last_mode_reg      <= 1'b0;
            rd_valid_reg       <= 1'b0;
            eval_en_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SRCH_LIMIT:     srch_limit_reg     <= cfg_data;
                    CFG_LOOKAHEAD_SIZE: lookahead_size_reg <= cfg_data[LENGTH_W-1:0];
                    CFG_MIN_MATCH:      min_match_reg      <= cfg_data[LENGTH_W-1:0];
                    default: begin
                    end
                endcase
            end
            wptr_reg      <= wptr_next;
            pending_reg   <= pending_next;
            history_reg   <= history_next;
            last_mode_reg <= last_mode_next;
            rd_valid_reg  <= rd_en;
            eval_en_reg   <= arr_ctrl.step && (32'(chain_cnt_reg) >= 32'(LOOKAHEAD - 1));
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        scan_ptr_reg <= scan_ptr_next;
        cnt_reg      <= cnt_next;
        drain_reg    <= drain_next;
        maxoff_reg   <= maxoff_next;
        lim_reg      <= lim_next;
        rd_scan_reg  <= rd_scan;
        if (scan_init) begin
            chain_cnt_reg <= '0;
            off_cnt_reg   <= maxoff;
            best_len_reg  <= '0;
            best_off_reg  <= '0;
        end else begin
            if (arr_ctrl.step) begin
                chain_cnt_reg <= chain_cnt_reg + AW'(1);
            end
            if (eval_en_reg) begin
                off_cnt_reg <= off_cnt_reg - HW'(1);
                if (run_len > best_len_reg) begin
                    best_len_reg <= run_len;
                    best_off_reg <= off_cnt_reg;
                end
            end
        end
        if (out_load) begin
            is_literal_reg    <= !is_match;
            literal_value_reg <= is_match ? '0 : head_byte;
            match_offset_reg  <= is_match ? OFFSET_W'(best_off_reg) : '0;
            match_length_reg  <= is_match ? LENGTH_W'(best_len_reg) : '0;
            stream_end_reg    <= last_mode_reg && !more;
        end
    end

    assign arr_ctrl = '{load: rd_valid_reg && !rd_scan_reg, step: rd_valid_reg && rd_scan_reg};

    lwm_byte_store #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wptr_reg),
        .wr_data (s_data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    lwm_match_array #(
        .LOOKAHEAD (LOOKAHEAD),
        .RW        (RW)
    ) u_array (
        .aclk      (aclk),
        .ctrl      (arr_ctrl),
        .lim       (lim_reg),
        .data_in   (rd_data),
        .run_len   (run_len),
        .head_byte (head_byte)
    );

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_is_literal    = is_literal_reg;
    assign m_literal_value = literal_value_reg;
    assign m_match_offset  = match_offset_reg;
    assign m_match_length  = match_length_reg;
    assign m_stream_end    = stream_end_reg;

endmodule

`default_nettype wire

/* src/lwm_checker.sv */
// Port-level checker for the LZSS encoder and the bind that attaches it to the top level.
// Depends on lwm_pkg and lzss_window_match_encoder_top.
`default_nettype none

module lwm_checker import lwm_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic                m_is_literal,
    input wire logic [BYTE_W-1:0]   m_literal_value,
    input wire logic [OFFSET_W-1:0] m_match_offset,
    input wire logic [LENGTH_W-1:0] m_match_length,
    input wire logic                m_stream_end
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_literal) &&
            $stable(m_literal_value) && $stable(m_match_offset) &&
            $stable(m_match_length) && $stable(m_stream_end))
        else $error("Stalled result item changed.");

    a_literal_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_literal |-> m_match_offset == '0 && m_match_length == '0)
        else $error("Literal item carries match fields.");

    a_match_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_literal |->
            m_literal_value == '0 && m_match_offset != '0 && m_match_length != '0)
        else $error("Match item has an empty offset or length.");

endmodule

bind lzss_window_match_encoder_top lwm_checker u_lwm_checker (.*);

`default_nettype wire
